// ----- rtl/dop_pkg.sv -----
`timescale 1ns / 1ps

package dop_pkg;

    // sizing
    localparam int MAX_SPATIAL    = 256;
    localparam int MAX_SPECTRAL   = 64;
    localparam int PIXEL_BITS     = 16;

    localparam int SPATIAL_CFG_W  = 9;
    localparam int SPECTRAL_CFG_W = 7;
    localparam int CFG_DATA_W     = 9;
    localparam int CFG_INDEX_W    = 1;
    localparam int PHOTON_W       = 16;
    localparam int POS_W          = 9;
    localparam int SUM_W          = 22;
    localparam int ROW_W          = $clog2(MAX_SPATIAL);
    localparam int SLOT_W         = $clog2(MAX_SPECTRAL);

    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    // register map
    localparam logic [CFG_INDEX_W-1:0] REG_SPATIAL_SIZE  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_SPECTRAL_SIZE = 1'b1;

    localparam logic [SPATIAL_CFG_W-1:0]  SPATIAL_RESET  = SPATIAL_CFG_W'(MAX_SPATIAL);
    localparam logic [SPECTRAL_CFG_W-1:0] SPECTRAL_RESET = SPECTRAL_CFG_W'(MAX_SPECTRAL);

    // one entry of the front-to-back queue
    typedef struct packed {
        logic                  flush;      // drain entry: read a slot and report it
        logic [PIXEL_BITS-1:0] pix;
        logic [SLOT_W-1:0]     ps;         // plus-order slot
        logic [SLOT_W-1:0]     ms;         // minus-order slot
        logic                  first_col;
        logic                  row_end;
        logic [POS_W-1:0]      pos;
        logic                  last;       // final result of the frame
    } dop_item_t;

    function automatic logic [ROW_W-1:0] eff_rows_m1(input logic [SPATIAL_CFG_W-1:0] size);
        logic [ROW_W-1:0] r;
        if (size == '0)
        begin
            r = '0;
        end
        else if (size >= SPATIAL_CFG_W'(MAX_SPATIAL))
        begin
            r = ROW_W'(MAX_SPATIAL - 1);
        end
        else
        begin
            r = ROW_W'(size - SPATIAL_CFG_W'(1));
        end
        return r;
    endfunction

    function automatic logic [SLOT_W-1:0] eff_cols_m1(input logic [SPECTRAL_CFG_W-1:0] size);
        logic [SLOT_W-1:0] c;
        if (size == '0)
        begin
            c = '0;
        end
        else if (size >= SPECTRAL_CFG_W'(MAX_SPECTRAL))
        begin
            c = SLOT_W'(MAX_SPECTRAL - 1);
        end
        else
        begin
            c = SLOT_W'(size - SPECTRAL_CFG_W'(1));
        end
        return c;
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

endpackage

// ----- rtl/dop_cfg_if.sv -----
`timescale 1ns / 1ps

interface dop_cfg_if import dop_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/dop_pixel_if.sv -----
`timescale 1ns / 1ps

interface dop_pixel_if import dop_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [PHOTON_W-1:0] photon_count;

    modport source (output valid, photon_count, input ready);
    modport sink   (input valid, photon_count, output ready);
endinterface

// ----- rtl/dop_result_if.sv -----
`timescale 1ns / 1ps

interface dop_result_if import dop_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] position;
    logic [SUM_W-1:0] zero_order_sum;
    logic             zero_valid;
    logic [SUM_W-1:0] plus_order_sum;
    logic [SUM_W-1:0] minus_order_sum;
    logic             frame_last;

    modport source (output valid, position, zero_order_sum, zero_valid, plus_order_sum,
                    minus_order_sum, frame_last, input ready);
    modport sink   (input valid, position, zero_order_sum, zero_valid, plus_order_sum,
                    minus_order_sum, frame_last, output ready);
endinterface

// ----- rtl/dop_front.sv -----
`timescale 1ns / 1ps

module dop_front import dop_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    dop_cfg_if.sink     cfg,
    dop_pixel_if.sink   pix,
    output logic        frame_clear,
    output logic        push_valid,
    output dop_item_t   push_item,
    input  logic        push_ready
);

    logic [SPATIAL_CFG_W-1:0]  spatial_reg,  spatial_next;
    logic [SPECTRAL_CFG_W-1:0] spectral_reg, spectral_next;
    logic [ROW_W-1:0]          row_reg,      row_next;
    logic [SLOT_W-1:0]         col_reg,      col_next;
    logic [SLOT_W-1:0]         base_reg,     base_next;
    logic                      flush_reg,    flush_next;
    logic [SLOT_W-1:0]         flush_k_reg,  flush_k_next;

    logic [ROW_W-1:0]  rows_m1;
    logic [SLOT_W-1:0] cols_m1;
    logic              col_last;
    logic              row_last;
    logic              pix_acc;
    logic              cfg_acc;
    logic [SLOT_W-1:0] flush_slot;

    assign rows_m1  = eff_rows_m1(spatial_reg);
    assign cols_m1  = eff_cols_m1(spectral_reg);
    assign col_last = (col_reg == cols_m1);
    assign row_last = (row_reg == rows_m1);

    assign cfg.ready   = 1'b1;
    assign cfg_acc     = cfg.valid && cfg.ready;
    assign frame_clear = cfg_acc;

    // pixels wait while the drain entries of a finished frame go out
    assign pix.ready = !flush_reg && push_ready;
    assign pix_acc   = pix.valid && pix.ready;

    assign push_valid = pix_acc || flush_reg;
    assign flush_slot = base_reg + flush_k_reg;

    always_comb
    begin
        if (flush_reg)
        begin
            push_item.flush     = 1'b1;
            push_item.pix       = '0;
            push_item.ps        = flush_slot;
            push_item.ms        = flush_slot;
            push_item.first_col = 1'b0;
            push_item.row_end   = 1'b0;
            push_item.pos       = POS_W'(row_reg) + POS_W'(flush_k_reg);
            push_item.last      = (flush_k_reg == cols_m1);
        end
        else
        begin
            push_item.flush     = 1'b0;
            push_item.pix       = pix.photon_count[PIXEL_BITS-1:0];
            push_item.ps        = base_reg + cols_m1 - col_reg;
            push_item.ms        = base_reg + col_reg;
            push_item.first_col = (col_reg == '0);
            push_item.row_end   = col_last;
            push_item.pos       = POS_W'(row_reg);
            push_item.last      = col_last && row_last && (cols_m1 == '0);
        end
    end

    always_comb
    begin
        spatial_next  = spatial_reg;
        spectral_next = spectral_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        base_next     = base_reg;
        flush_next    = flush_reg;
        flush_k_next  = flush_k_reg;
        priority if (cfg_acc)
        begin
            unique case (cfg.index)
                REG_SPATIAL_SIZE:  spatial_next  = cfg.data[SPATIAL_CFG_W-1:0];
                REG_SPECTRAL_SIZE: spectral_next = cfg.data[SPECTRAL_CFG_W-1:0];
                default:           spatial_next  = spatial_reg;
            endcase
            row_next   = '0;
            col_next   = '0;
            base_next  = '0;
            flush_next = 1'b0;
        end
        else if (flush_reg && push_ready)
        begin
            if (flush_k_reg == cols_m1)
            begin
                flush_next = 1'b0;
                row_next   = '0;
                base_next  = '0;
            end
            else
            begin
                flush_k_next = flush_k_reg + SLOT_W'(1);
            end
        end
        else if (pix_acc)
        begin
            col_next = col_last ? '0 : col_reg + SLOT_W'(1);
            if (col_last)
            begin
                if (!row_last)
                begin
                    row_next  = row_reg + ROW_W'(1);
                    base_next = base_reg + SLOT_W'(1);
                end
                else if (cols_m1 == '0)
                begin
                    row_next  = '0;
                    base_next = '0;
                end
                else
                begin
                    flush_next   = 1'b1;
                    flush_k_next = SLOT_W'(1);
                end
            end
        end
        else
        begin
            // idle: everything holds
            flush_next = flush_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spatial_reg  <= SPATIAL_RESET;
            spectral_reg <= SPECTRAL_RESET;
            row_reg      <= '0;
            col_reg      <= '0;
            base_reg     <= '0;
            flush_reg    <= 1'b0;
            flush_k_reg  <= '0;
        end
        else
        begin
            spatial_reg  <= spatial_next;
            spectral_reg <= spectral_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            base_reg     <= base_next;
            flush_reg    <= flush_next;
            flush_k_reg  <= flush_k_next;
        end
    end

endmodule

// ----- rtl/dop_queue.sv -----
`timescale 1ns / 1ps

module dop_queue import dop_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    input  dop_item_t push_item,
    output logic      push_ready,
    output logic      pop_valid,
    output dop_item_t pop_item,
    input  logic      pop_ready
);

    dop_item_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg,  count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/dop_back.sv -----
`timescale 1ns / 1ps

module dop_back import dop_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          frame_clear,
    input  logic          pop_valid,
    input  dop_item_t     pop_item,
    output logic          pop_ready,
    dop_result_if.source  res
);

    // diagonal accumulator rings, registered read
    logic [SUM_W-1:0]        plus_mem  [MAX_SPECTRAL];
    logic [SUM_W-1:0]        minus_mem [MAX_SPECTRAL];
    logic [SUM_W-1:0]        p_rd_reg;
    logic [SUM_W-1:0]        m_rd_reg;
    logic [MAX_SPECTRAL-1:0] p_vld_reg, p_vld_next;
    logic [MAX_SPECTRAL-1:0] m_vld_reg, m_vld_next;

    // last write to each ring, forwarded over the read latency
    logic              lwp_valid_reg;
    logic [SLOT_W-1:0] lwp_addr_reg;
    logic [SUM_W-1:0]  lwp_data_reg;
    logic              lwm_valid_reg;
    logic [SLOT_W-1:0] lwm_addr_reg;
    logic [SUM_W-1:0]  lwm_data_reg;

    logic              b_valid_reg;
    dop_item_t         b_item_reg;
    logic [SUM_W-1:0]  row_acc_reg;
    logic [SUM_W-1:0]  m_cap_reg;

    logic              out_valid_reg;
    logic [POS_W-1:0]  out_pos_reg;
    logic [SUM_W-1:0]  out_zsum_reg;
    logic              out_zvalid_reg;
    logic [SUM_W-1:0]  out_plus_reg;
    logic [SUM_W-1:0]  out_minus_reg;
    logic              out_last_reg;

    logic [SUM_W-1:0]  p_cur, m_cur, pix_ext, p_sum, m_sum, r_sum;
    logic [SUM_W-1:0]  p_wdata, m_wdata;
    logic [SUM_W-1:0]  res_zsum, res_plus, res_minus;
    logic              emits, out_free, b_done, advance, wr_en, clear_all;

    always_comb
    begin
        if (lwp_valid_reg && (lwp_addr_reg == b_item_reg.ps))
        begin
            p_cur = lwp_data_reg;
        end
        else
        begin
            p_cur = p_vld_reg[b_item_reg.ps] ? p_rd_reg : '0;
        end
        if (lwm_valid_reg && (lwm_addr_reg == b_item_reg.ms))
        begin
            m_cur = lwm_data_reg;
        end
        else
        begin
            m_cur = m_vld_reg[b_item_reg.ms] ? m_rd_reg : '0;
        end
    end

    assign pix_ext = SUM_W'(b_item_reg.pix);
    assign p_sum   = sat_add(p_cur, pix_ext);
    assign m_sum   = sat_add(m_cur, pix_ext);
    assign r_sum   = sat_add(row_acc_reg, pix_ext);

    assign emits     = b_item_reg.flush || b_item_reg.row_end;
    assign out_free  = !out_valid_reg || res.ready;
    assign b_done    = b_valid_reg && (!emits || out_free);
    assign pop_ready = !b_valid_reg || b_done;
    assign advance   = pop_valid && pop_ready;
    assign clear_all = frame_clear || (b_done && b_item_reg.last);
    assign wr_en     = b_done && !b_item_reg.flush && !clear_all;

    // a finished slot is reported and zeroed in the same pass
    assign p_wdata = b_item_reg.row_end   ? '0 : p_sum;
    assign m_wdata = b_item_reg.first_col ? '0 : m_sum;

    always_comb
    begin
        if (b_item_reg.flush)
        begin
            res_zsum  = '0;
            res_plus  = p_cur;
            res_minus = m_cur;
        end
        else
        begin
            res_zsum  = r_sum;
            res_plus  = p_sum;
            res_minus = b_item_reg.first_col ? m_sum : m_cap_reg;
        end
    end

    always_comb
    begin
        p_vld_next = p_vld_reg;
        m_vld_next = m_vld_reg;
        if (clear_all)
        begin
            p_vld_next = '0;
            m_vld_next = '0;
        end
        else if (wr_en)
        begin
            p_vld_next[b_item_reg.ps] = 1'b1;
            m_vld_next[b_item_reg.ms] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            plus_mem[b_item_reg.ps]  <= p_wdata;
            minus_mem[b_item_reg.ms] <= m_wdata;
        end
        if (advance)
        begin
            p_rd_reg <= plus_mem[pop_item.ps];
            m_rd_reg <= minus_mem[pop_item.ms];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_item_reg <= pop_item;
        end
        if (wr_en)
        begin
            lwp_addr_reg <= b_item_reg.ps;
            lwp_data_reg <= p_wdata;
            lwm_addr_reg <= b_item_reg.ms;
            lwm_data_reg <= m_wdata;
        end
        if (b_done && !b_item_reg.flush && b_item_reg.first_col)
        begin
            m_cap_reg <= m_sum;
        end
        if (b_done && emits)
        begin
            out_pos_reg    <= b_item_reg.pos;
            out_zsum_reg   <= res_zsum;
            out_zvalid_reg <= !b_item_reg.flush;
            out_plus_reg   <= res_plus;
            out_minus_reg  <= res_minus;
            out_last_reg   <= b_item_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg     <= '0;
            m_vld_reg     <= '0;
            lwp_valid_reg <= 1'b0;
            lwm_valid_reg <= 1'b0;
            b_valid_reg   <= 1'b0;
            row_acc_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            p_vld_reg <= p_vld_next;
            m_vld_reg <= m_vld_next;
            if (clear_all)
            begin
                lwp_valid_reg <= 1'b0;
                lwm_valid_reg <= 1'b0;
            end
            else if (wr_en)
            begin
                lwp_valid_reg <= 1'b1;
                lwm_valid_reg <= 1'b1;
            end
            if (advance)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (b_done)
            begin
                b_valid_reg <= 1'b0;
            end
            if (frame_clear)
            begin
                row_acc_reg <= '0;
            end
            else if (b_done && !b_item_reg.flush)
            begin
                row_acc_reg <= b_item_reg.row_end ? '0 : r_sum;
            end
            if (b_done && emits)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.position        = out_pos_reg;
    assign res.zero_order_sum  = out_zsum_reg;
    assign res.zero_valid      = out_zvalid_reg;
    assign res.plus_order_sum  = out_plus_reg;
    assign res.minus_order_sum = out_minus_reg;
    assign res.frame_last      = out_last_reg;

endmodule

// ----- rtl/diagonal_order_projector.sv -----
`timescale 1ns / 1ps

// Row and diagonal projection sums over one spatial x spectral frame.
// cfg : write transaction, index 0 = spatial_size (rows), 1 = spectral_size
//       (pixels per row). Always ready. A write restarts the frame; issue it
//       only while no pixel is in flight.
// pix : one photon_count per transaction, raster order, row major.
// res : one transaction per completed position: at the end of each row
//       (row sum, plus and minus sums) and, after the last row,
//       spectral_size-1 transactions for the trailing diagonal positions;
//       the last result of the frame has frame_last set.
// Throughput: one pixel per clock while the queue has room. At the end of a
// frame pix.ready drops while the drain entries for the trailing positions
// are issued from the front end into the queue.
// A row-end pixel's result reaches res through the queue write, then the
// ring read, then the add into the output register.
// Reset: sizes 256 x 64, counters and all accumulators empty.
// When res is stalled the output register holds, the back end stops and the
// four-entry queue fills; pix.ready then drops until room opens again.

module diagonal_order_projector import dop_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    dop_cfg_if.sink       cfg,
    dop_pixel_if.sink     pix,
    dop_result_if.source  res
);

    logic      frame_clear;
    logic      push_valid;
    logic      push_ready;
    dop_item_t push_item;
    logic      pop_valid;
    logic      pop_ready;
    dop_item_t pop_item;

    // front: config registers, raster counters, slot classification, drain issue
    dop_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .pix         (pix),
        .frame_clear (frame_clear),
        .push_valid  (push_valid),
        .push_item   (push_item),
        .push_ready  (push_ready)
    );

    // decouples the front from back-end and output stalls
    dop_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready)
    );

    // back: ring accumulators with forwarding, row sum, output register
    dop_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_clear (frame_clear),
        .pop_valid   (pop_valid),
        .pop_item    (pop_item),
        .pop_ready   (pop_ready),
        .res         (res)
    );

`ifndef SYNTHESIS
    // an accepted pixel always lands in the queue in the same cycle
    a_pix_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (pix.valid && pix.ready) |-> (push_valid && push_ready))
        else $error("pixel accepted without queue room");

    // an empty queue must offer room
    a_empty_room: assert property (@(posedge clk) disable iff (!rst_n)
        !pop_valid |-> push_ready)
        else $error("queue empty but not ready");

    // a result leaves the back end only after an entry was taken from the queue
    a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res.valid) |-> $past(pop_valid && pop_ready, 2))
        else $error("result without a queue transaction");
`endif

endmodule
